// ===== rtl/core/polyprod_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// polyprod_pkg
// Shared widths, codes and control bundle for the polynomial product block.
// ----------------------------------------------------------------------------
package polyprod_pkg;

   localparam int MAX_COEFFS = 32;
   localparam int INDEX_W    = $clog2(MAX_COEFFS);
   localparam int COUNT_W    = 6;
   localparam int COEFF_W    = 16;
   localparam int PROD_W     = 2 * COEFF_W;
   localparam int VALUE_W    = 40;

   typedef enum logic [1:0] {
      FUNC_LOAD_A  = 2'd0,
      FUNC_LOAD_B  = 2'd1,
      FUNC_COMPUTE = 2'd2,
      FUNC_NONE    = 2'd3
   } func_type;

   typedef enum logic {
      REG_A_COUNT = 1'b0,
      REG_B_COUNT = 1'b1
   } reg_index_type;

   // bundle broadcast from the sequencer to every cell
   typedef struct packed {
      logic                       load;
      logic [INDEX_W-1:0]         load_idx;
      logic signed [COEFF_W-1:0]  load_value;
      logic                       step;
      logic                       clear;
      logic signed [COEFF_W-1:0]  x;
      logic [COUNT_W-1:0]         active_count;
   } cell_ctl_type;

endpackage
`default_nettype wire

// ===== rtl/core/polynomial_product.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// polynomial_product
// Loads two coefficient sets and streams their full linear convolution
// through a row of multiply-accumulate cells.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata (low bit up)                    | tuser | tlast
//  req_     | in        | coeff_index[4:0], coeff_value[15:0]   | func  | -
//  rsp_     | out       | product_index[5:0], product_value[39:0]| -    | last
//  csr_     | in        | csr_index 0 a_count, 1 b_count; csr_wdata 6 bits
//
// a compute word produces a_count+b_count-1 result words, one per cycle while
// rsp_tready holds; each passes the second-coefficient memory read register,
// then the chain head register. a stalled result word freezes the sequencer
// and the whole cell row.
// reset is synchronous; it sets both counts to 1 and leaves the coefficient
// stores as they are.
// ----------------------------------------------------------------------------
module polynomial_product (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // coeff_index[4:0], coeff_value[20:5], zero pad
   input  logic [1:0]  req_tuser,   // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // product_index[5:0], product_value[45:6], zero pad
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [5:0]  csr_wdata
);

   localparam int N  = polyprod_pkg::MAX_COEFFS;
   localparam int VW = polyprod_pkg::VALUE_W;

   polyprod_pkg::cell_ctl_type                 ctl;
   logic signed [VW-1:0]                       acc [N+1];
   logic [polyprod_pkg::COUNT_W-1:0]           rsp_index;

   polyprod_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (polyprod_pkg::func_type'(req_tuser)),
      .req_index  (req_tdata[4:0]),
      .req_value  ($signed(req_tdata[20:5])),
      .csr_we     (csr_we),
      .csr_index  (polyprod_pkg::reg_index_type'(csr_index)),
      .csr_wdata  (csr_wdata),
      .ctl        (ctl),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_index  (rsp_index),
      .rsp_tlast  (rsp_tlast)
   );

   // partial sums move toward cell 0, whose register is the result word
   assign acc[N] = '0;

   for (genvar i = 0; i < N; i++) begin : g_cell
      polyprod_cell u_cell (
         .clock   (clock),
         .cell_id (polyprod_pkg::INDEX_W'(i)),
         .ctl     (ctl),
         .acc_in  (acc[i+1]),
         .acc_out (acc[i])
      );
   end

   assign rsp_tdata = {2'b00, acc[0], rsp_index};

endmodule
`default_nettype wire

// ===== rtl/core/polyprod_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// polyprod_cell
// One tap of the transposed convolution chain: holds one first-polynomial
// coefficient and one partial sum, adds its product to the neighbour's sum.
// ----------------------------------------------------------------------------
module polyprod_cell (
   input  logic                                        clock,
   input  logic [polyprod_pkg::INDEX_W-1:0]            cell_id,
   input  polyprod_pkg::cell_ctl_type                  ctl,
   input  logic signed [polyprod_pkg::VALUE_W-1:0]     acc_in,
   output logic signed [polyprod_pkg::VALUE_W-1:0]     acc_out
);

   logic signed [polyprod_pkg::COEFF_W-1:0] coeff_ff;
   logic signed [polyprod_pkg::VALUE_W-1:0] acc_ff;
   logic signed [polyprod_pkg::VALUE_W-1:0] acc_in_sum;
   logic signed [polyprod_pkg::PROD_W-1:0]  mult;
   logic signed [polyprod_pkg::PROD_W-1:0]  prod;
   logic                                    active;

   // signed product formed on its own so both operands sign-extend
   assign mult   = coeff_ff * ctl.x;

   // taps at or beyond the first polynomial's length contribute nothing
   assign active = ({1'b0, cell_id} < ctl.active_count);
   assign prod   = active ? mult : '0;
   assign acc_in_sum = acc_in +
      {{(polyprod_pkg::VALUE_W - polyprod_pkg::PROD_W){prod[polyprod_pkg::PROD_W-1]}}, prod};

   always_ff @(posedge clock) begin
      if (ctl.load && (ctl.load_idx == cell_id)) begin
         coeff_ff <= ctl.load_value;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         acc_ff <= '0;
      end else if (ctl.step) begin
         acc_ff <= acc_in_sum;
      end
   end

   assign acc_out = acc_ff;

endmodule
`default_nettype wire

// ===== rtl/core/polyprod_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// polyprod_seq
// Input decode, count registers, second-coefficient memory and the step
// sequencer that feeds the cell chain and tags each result word.
// ----------------------------------------------------------------------------
module polyprod_seq (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  polyprod_pkg::func_type                    req_func,
   input  logic [polyprod_pkg::INDEX_W-1:0]          req_index,
   input  logic signed [polyprod_pkg::COEFF_W-1:0]   req_value,
   input  logic                                      csr_we,
   input  polyprod_pkg::reg_index_type               csr_index,
   input  logic [polyprod_pkg::COUNT_W-1:0]          csr_wdata,
   output polyprod_pkg::cell_ctl_type                ctl,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [polyprod_pkg::COUNT_W-1:0]          rsp_index,
   output logic                                      rsp_tlast
);

   localparam int CW = polyprod_pkg::COUNT_W;

   logic [CW-1:0] a_count_ff, a_count_in;
   logic [CW-1:0] b_count_ff, b_count_in;
   logic [CW-1:0] ac, bc, total;

   logic          issue_ff, issue_in;
   logic [CW-1:0] k_ff, k_in;
   logic          s1_valid_ff, s1_valid_in;
   logic [CW-1:0] s1_idx_ff;
   logic          s1_inb_ff;
   logic          s1_last_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] rsp_idx_ff;
   logic          rsp_last_ff;

   logic signed [polyprod_pkg::COEFF_W-1:0] b_mem [polyprod_pkg::MAX_COEFFS];
   logic signed [polyprod_pkg::COEFF_W-1:0] rd_ff;

   logic accept, start, adv, issue_end;

   function automatic logic [CW-1:0] eff_count(input logic [CW-1:0] c);
      logic [CW-1:0] r;
      r = c;
      if (c == '0) begin
         r = CW'(1);
      end else if (c > CW'(polyprod_pkg::MAX_COEFFS)) begin
         r = CW'(polyprod_pkg::MAX_COEFFS);
      end
      return r;
   endfunction

   assign ac    = eff_count(a_count_ff);
   assign bc    = eff_count(b_count_ff);
   assign total = ac + bc - CW'(1);

   assign req_tready = !(issue_ff || s1_valid_ff || rsp_valid_ff);
   assign accept     = req_tvalid && req_tready;
   assign start      = accept && (req_func == polyprod_pkg::FUNC_COMPUTE);
   // the whole chain freezes while a result word waits
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign issue_end  = issue_ff && adv && (k_ff == total - CW'(1));

   always_comb begin
      a_count_in = a_count_ff;
      b_count_in = b_count_ff;
      if (csr_we) begin
         case (csr_index)
            polyprod_pkg::REG_A_COUNT: a_count_in = csr_wdata;
            polyprod_pkg::REG_B_COUNT: b_count_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      issue_in     = issue_ff;
      k_in         = k_ff;
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (start) begin
         issue_in = 1'b1;
         k_in     = '0;
      end else if (adv && issue_ff) begin
         k_in = k_ff + CW'(1);
         if (issue_end) begin
            issue_in = 1'b0;
         end
      end
      if (adv) begin
         s1_valid_in  = issue_ff;
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_count_ff   <= CW'(1);
         b_count_ff   <= CW'(1);
         issue_ff     <= 1'b0;
         k_ff         <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_count_ff   <= a_count_in;
         b_count_ff   <= b_count_in;
         issue_ff     <= issue_in;
         k_ff         <= k_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // tags travel alongside the read word and the chain head
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_idx_ff   <= k_ff;
         s1_inb_ff   <= (k_ff < bc);
         s1_last_ff  <= (k_ff == total - CW'(1));
         rsp_idx_ff  <= s1_idx_ff;
         rsp_last_ff <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req_func == polyprod_pkg::FUNC_LOAD_B)) begin
         b_mem[req_index] <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rd_ff <= b_mem[k_ff[polyprod_pkg::INDEX_W-1:0]];
      end
   end

   always_comb begin
      ctl.load         = accept && (req_func == polyprod_pkg::FUNC_LOAD_A);
      ctl.load_idx     = req_index;
      ctl.load_value   = req_value;
      ctl.step         = adv && s1_valid_ff;
      ctl.clear        = start;
      ctl.x            = s1_inb_ff ? rd_ff : '0;
      ctl.active_count = ac;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_index  = rsp_idx_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_ready_only_when_empty: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!rsp_valid_ff && !s1_valid_ff && !issue_ff))
      else $error("input accepted while a product is in flight");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_idx_ff == total - CW'(1)))
      else $error("last word carries the wrong index");

   a_issue_stops: assert property (@(posedge clock) disable iff (reset)
      issue_end |=> !issue_ff)
      else $error("sequencer ran past the final coefficient");

   a_stall_holds_chain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> ($stable(rsp_idx_ff) && $stable(k_ff)))
      else $error("chain advanced while a result word was stalled");

endmodule
`default_nettype wire
